@@ rtl/point_line_projection_defines.svh @@
// ----------------------------------------------------------------------------
// Point/line projection assertion macros
// Shared concurrent assertion templates, clocked on aclk, reset by aresetn.
// ----------------------------------------------------------------------------
`ifndef POINT_LINE_PROJECTION_DEFINES_SVH
`define POINT_LINE_PROJECTION_DEFINES_SVH

// same-cycle implication
`define PLP_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PLP_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/plp_pkg.sv @@
// ----------------------------------------------------------------------------
// plp_pkg
// Widths, types and helpers for the point/line projection pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package plp_pkg;

    localparam int CW   = 24;          // coordinate width
    localparam int DW   = CW + 1;      // difference width
    localparam int PW   = 2 * DW;      // product width
    localparam int LW   = PW + 2;      // sum of three products
    localparam int TW   = 52;          // threshold register width
    localparam int QW   = CW + 3;      // quotient width
    localparam int NUMW = LW + DW + 2; // dividend width
    localparam int DENW = LW + 1;      // divisor width
    localparam int SATW = CW + 5;      // pre-saturation width
    localparam int NST  = QW + 8;      // pipeline depth

    typedef logic signed [CW-1:0]   coord_t;
    typedef logic signed [DW-1:0]   diff_t;
    typedef logic signed [CW+1:0]   pw_t;
    typedef logic        [DW-1:0]   mag_t;
    typedef logic        [PW-1:0]   prod_t;
    typedef logic        [LW-1:0]   sum_t;
    typedef logic        [TW-1:0]   thr_t;
    typedef logic        [NUMW-1:0] num_t;
    typedef logic        [DENW-1:0] den_t;
    typedef logic        [QW-1:0]   quo_t;
    typedef logic signed [SATW-1:0] sat_t;

    typedef struct packed {
        coord_t [2:0] a;
        coord_t [2:0] b;
        pw_t    [2:0] pw;
        logic   [2:0] sneg;
        logic         degen;
    } side_t;

    function automatic mag_t abs_mag(input diff_t v);
        diff_t n;
        n = -v;
        return v[DW-1] ? mag_t'(n) : mag_t'(v);
    endfunction

    function automatic coord_t sat_coord(input sat_t v);
        coord_t cmax;
        coord_t cmin;
        cmax = {1'b0, {(CW-1){1'b1}}};
        cmin = {1'b1, {(CW-1){1'b0}}};
        if (v > sat_t'(cmax)) begin
            return cmax;
        end else if (v < sat_t'(cmin)) begin
            return cmin;
        end
        return coord_t'(v);
    endfunction

endpackage

`default_nettype wire

@@ rtl/plp_div.sv @@
// ----------------------------------------------------------------------------
// plp_div
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module plp_div (
    input  wire logic         aclk,
    input  wire logic         en,
    input  wire plp_pkg::num_t num_i,
    input  wire plp_pkg::den_t den_i,
    output plp_pkg::quo_t      quo_o
);
    import plp_pkg::*;

    den_t rem_reg [QW];
    quo_t lq_reg  [QW];
    den_t dv_reg  [QW];

    den_t rem_in  [QW];
    quo_t lq_in   [QW];
    den_t dv_in   [QW];
    den_t rem_next[QW];
    quo_t lq_next [QW];

    always_comb begin
        rem_in[0] = den_t'(num_i[NUMW-1:QW]);
        lq_in[0]  = num_i[QW-1:0];
        dv_in[0]  = den_i;
        for (int s = 1; s < QW; s++) begin
            rem_in[s] = rem_reg[s-1];
            lq_in[s]  = lq_reg[s-1];
            dv_in[s]  = dv_reg[s-1];
        end
        for (int s = 0; s < QW; s++) begin
            logic [DENW:0] t;
            logic          ge;
            t  = {rem_in[s], lq_in[s][QW-1]};
            ge = t >= {1'b0, dv_in[s]};
            rem_next[s] = ge ? den_t'(t - {1'b0, dv_in[s]}) : den_t'(t);
            lq_next[s]  = {lq_in[s][QW-2:0], ge};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int s = 0; s < QW; s++) begin
                rem_reg[s] <= rem_next[s];
                lq_reg[s]  <= lq_next[s];
                dv_reg[s]  <= dv_in[s];
            end
        end
    end

    assign quo_o = lq_reg[QW-1];

endmodule

`default_nettype wire

@@ rtl/point_line_projection.sv @@
// ----------------------------------------------------------------------------
// point_line_projection
// Projects a point onto a 3D line and moves the current projection to match.
// ----------------------------------------------------------------------------
// Input channel (s_valid/s_ready) takes one word per cycle: point W, line
// points A and B and current projection P, signed Q8.16. Result channel
// (m_valid/m_ready) returns foot F on line AB, moved point P + W - F and the
// degenerate flag, one word per input word, in order.
// The pipeline has six arithmetic stages, a 27-stage divider (one quotient
// bit per stage, three in parallel, one per axis), a foot stage and the
// output register. Throughput is one word per cycle.
// When m_valid is high and m_ready low the whole pipeline holds and s_ready
// drops; nothing is lost or repeated.
// cfg_wr_en/cfg_wr_data write the degenerate threshold (|B-A|^2 units of
// 2^-32) at any edge; reset sets it to 1. A synchronous, active-low aresetn
// empties the pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "point_line_projection_defines.svh"

module point_line_projection (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              cfg_wr_en,
    input  wire plp_pkg::thr_t     cfg_wr_data,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire plp_pkg::coord_t   s_point_x,
    input  wire plp_pkg::coord_t   s_point_y,
    input  wire plp_pkg::coord_t   s_point_z,
    input  wire plp_pkg::coord_t   s_line_a_x,
    input  wire plp_pkg::coord_t   s_line_a_y,
    input  wire plp_pkg::coord_t   s_line_a_z,
    input  wire plp_pkg::coord_t   s_line_b_x,
    input  wire plp_pkg::coord_t   s_line_b_y,
    input  wire plp_pkg::coord_t   s_line_b_z,
    input  wire plp_pkg::coord_t   s_current_proj_x,
    input  wire plp_pkg::coord_t   s_current_proj_y,
    input  wire plp_pkg::coord_t   s_current_proj_z,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output plp_pkg::coord_t        m_foot_x,
    output plp_pkg::coord_t        m_foot_y,
    output plp_pkg::coord_t        m_foot_z,
    output plp_pkg::coord_t        m_moved_point_x,
    output plp_pkg::coord_t        m_moved_point_y,
    output plp_pkg::coord_t        m_moved_point_z,
    output logic                   m_degenerate
);
    import plp_pkg::*;

    logic en;
    thr_t thr_reg;
    logic [NST-1:0] vld_reg;

    coord_t w_in [3];
    coord_t a_in [3];
    coord_t b_in [3];
    coord_t p_in [3];

    // stage 1
    diff_t  d1_reg [3];
    diff_t  r1_reg [3];
    coord_t a1_reg [3];
    coord_t b1_reg [3];
    pw_t    pw1_reg[3];
    // stage 2
    mag_t   dabs2_reg[3];
    prod_t  dd2_reg  [3];
    prod_t  rd2_reg  [3];
    logic   ns2_reg  [3];
    logic   ds2_reg  [3];
    coord_t a2_reg [3];
    coord_t b2_reg [3];
    pw_t    pw2_reg[3];
    // stage 3
    sum_t   len3_reg;
    sum_t   pos3_reg;
    sum_t   neg3_reg;
    mag_t   dabs3_reg[3];
    logic   ds3_reg  [3];
    coord_t a3_reg [3];
    coord_t b3_reg [3];
    pw_t    pw3_reg[3];
    // stage 4
    sum_t   len4_reg;
    sum_t   dmag4_reg;
    mag_t   dabs4_reg[3];
    side_t  side4_reg;
    // stage 5
    prod_t  lo5_reg[3];
    sum_t   hi5_reg[3];
    sum_t   len5_reg;
    side_t  side5_reg;
    // stage 6
    num_t   num6_reg[3];
    den_t   den6_reg;
    side_t  side6_reg;
    // divider side band
    side_t  sdiv_reg[QW];
    quo_t   quo[3];
    // foot stage
    coord_t foot_reg[3];
    side_t  sf_reg;

    side_t  side4_next;
    logic   dneg4;
    coord_t foot_next[3];

    assign en      = m_ready || !m_valid;
    assign s_ready = en;
    assign m_valid = vld_reg[NST-1];

    assign w_in = '{s_point_x, s_point_y, s_point_z};
    assign a_in = '{s_line_a_x, s_line_a_y, s_line_a_z};
    assign b_in = '{s_line_b_x, s_line_b_y, s_line_b_z};
    assign p_in = '{s_current_proj_x, s_current_proj_y, s_current_proj_z};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg <= thr_t'(1);
        end else if (cfg_wr_en) begin
            thr_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[NST-2:0], s_valid};
        end
    end

    always_comb begin
        dneg4 = neg3_reg > pos3_reg;
        side4_next.a     = '{a3_reg[0], a3_reg[1], a3_reg[2]};
        side4_next.b     = '{b3_reg[0], b3_reg[1], b3_reg[2]};
        side4_next.pw    = '{pw3_reg[0], pw3_reg[1], pw3_reg[2]};
        side4_next.sneg  = {dneg4 ^ ds3_reg[0], dneg4 ^ ds3_reg[1], dneg4 ^ ds3_reg[2]};
        side4_next.degen = (len3_reg == '0) || (len3_reg < sum_t'(thr_reg));
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            sat_t off;
            off = sdiv_reg[QW-1].sneg[2-i] ? -sat_t'(quo[i]) : sat_t'(quo[i]);
            foot_next[i] = sdiv_reg[QW-1].degen ? sdiv_reg[QW-1].b[2-i]
                         : sat_coord(sat_t'(sdiv_reg[QW-1].a[2-i]) + off);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                d1_reg[i]  <= diff_t'(b_in[i]) - diff_t'(a_in[i]);
                r1_reg[i]  <= diff_t'(w_in[i]) - diff_t'(a_in[i]);
                a1_reg[i]  <= a_in[i];
                b1_reg[i]  <= b_in[i];
                pw1_reg[i] <= pw_t'(p_in[i]) + pw_t'(w_in[i]);

                dabs2_reg[i] <= abs_mag(d1_reg[i]);
                dd2_reg[i]   <= prod_t'(abs_mag(d1_reg[i])) * prod_t'(abs_mag(d1_reg[i]));
                rd2_reg[i]   <= prod_t'(abs_mag(r1_reg[i])) * prod_t'(abs_mag(d1_reg[i]));
                ns2_reg[i]   <= r1_reg[i][DW-1] ^ d1_reg[i][DW-1];
                ds2_reg[i]   <= d1_reg[i][DW-1];
                a2_reg[i]    <= a1_reg[i];
                b2_reg[i]    <= b1_reg[i];
                pw2_reg[i]   <= pw1_reg[i];

                dabs3_reg[i] <= dabs2_reg[i];
                ds3_reg[i]   <= ds2_reg[i];
                a3_reg[i]    <= a2_reg[i];
                b3_reg[i]    <= b2_reg[i];
                pw3_reg[i]   <= pw2_reg[i];

                dabs4_reg[i] <= dabs3_reg[i];

                lo5_reg[i] <= prod_t'(dmag4_reg[DW-1:0]) * prod_t'(dabs4_reg[i]);
                hi5_reg[i] <= sum_t'(dmag4_reg[LW-1:DW]) * sum_t'(dabs4_reg[i]);

                num6_reg[i] <= (((num_t'(hi5_reg[i]) << DW) + num_t'(lo5_reg[i])) << 1)
                             + num_t'(len5_reg);

                foot_reg[i] <= foot_next[i];
            end
            len3_reg <= sum_t'(dd2_reg[0]) + sum_t'(dd2_reg[1]) + sum_t'(dd2_reg[2]);
            pos3_reg <= (ns2_reg[0] ? '0 : sum_t'(rd2_reg[0]))
                      + (ns2_reg[1] ? '0 : sum_t'(rd2_reg[1]))
                      + (ns2_reg[2] ? '0 : sum_t'(rd2_reg[2]));
            neg3_reg <= (ns2_reg[0] ? sum_t'(rd2_reg[0]) : '0)
                      + (ns2_reg[1] ? sum_t'(rd2_reg[1]) : '0)
                      + (ns2_reg[2] ? sum_t'(rd2_reg[2]) : '0);

            len4_reg  <= len3_reg;
            dmag4_reg <= dneg4 ? neg3_reg - pos3_reg : pos3_reg - neg3_reg;
            side4_reg <= side4_next;

            len5_reg  <= len4_reg;
            side5_reg <= side4_reg;

            den6_reg  <= {len5_reg, 1'b0};
            side6_reg <= side5_reg;

            sdiv_reg[0] <= side6_reg;
            for (int s = 1; s < QW; s++) begin
                sdiv_reg[s] <= sdiv_reg[s-1];
            end
            sf_reg <= sdiv_reg[QW-1];

            m_foot_x        <= foot_reg[0];
            m_foot_y        <= foot_reg[1];
            m_foot_z        <= foot_reg[2];
            m_moved_point_x <= sat_coord(sat_t'(sf_reg.pw[2]) - sat_t'(foot_reg[0]));
            m_moved_point_y <= sat_coord(sat_t'(sf_reg.pw[1]) - sat_t'(foot_reg[1]));
            m_moved_point_z <= sat_coord(sat_t'(sf_reg.pw[0]) - sat_t'(foot_reg[2]));
            m_degenerate    <= sf_reg.degen;
        end
    end

    for (genvar g = 0; g < 3; g++) begin : g_div
        plp_div u_div (
            .aclk  (aclk),
            .en    (en),
            .num_i (num6_reg[g]),
            .den_i (den6_reg),
            .quo_o (quo[g])
        );
    end

    `PLP_ASSERT_IMP(a_degen_foot, vld_reg[NST-2] && sf_reg.degen, foot_reg[0] == sf_reg.b[2] && foot_reg[1] == sf_reg.b[1] && foot_reg[2] == sf_reg.b[0], "degenerate foot differs from second line point")
    `PLP_ASSERT_IMP(a_zero_len_degen, vld_reg[5] && den6_reg == '0, side6_reg.degen, "zero-length line not flagged degenerate")
    `PLP_ASSERT_NXT(a_stall_hold, !s_ready, $stable(vld_reg), "pipeline moved during stall")

endmodule

`default_nettype wire
